### src/assert_macros.svh
// Concurrent assertion helpers, clocked on clk with asynchronous reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every rising edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### src/b64w_pkg.sv
package b64w_pkg;

	localparam int unsigned CharW   = 8;
	localparam int unsigned SextetW = 6;
	localparam int unsigned WordW   = 32;
	localparam int unsigned IndexW  = 16;
	localparam int unsigned FcountW = 17;
	localparam logic [FcountW-1:0] FcountReset = 17'd128;

	typedef enum logic [1:0] {
		CLS_OK  = 2'd0,
		CLS_PAD = 2'd1,
		CLS_BAD = 2'd2
	} sym_class_t;

	typedef struct packed {
		sym_class_t               cls;
		logic [SextetW-1:0]       val;
	} symbol_t;

	typedef struct packed {
		logic [WordW-1:0]  word_bits;
		logic [IndexW-1:0] word_index;
		logic              is_status;
		logic              short_input;
		logic              stopped_early;
		logic              last_of_run;
	} result_t;

	function automatic symbol_t classify(input logic [CharW-1:0] c);
		symbol_t s;
		s.cls = CLS_OK;
		s.val = '0;
		if (c >= "A" && c <= "Z") begin
			s.val = SextetW'(c - 8'd65);
		end else if (c >= "a" && c <= "z") begin
			s.val = SextetW'(c - 8'd97 + 8'd26);
		end else if (c >= "0" && c <= "9") begin
			s.val = SextetW'(c - 8'd48 + 8'd52);
		end else if (c == "+") begin
			s.val = 6'd62;
		end else if (c == "/") begin
			s.val = 6'd63;
		end else if (c == "=") begin
			s.cls = CLS_PAD;
		end else begin
			s.cls = CLS_BAD;
		end
		return s;
	endfunction

endpackage

### src/b64w_if.sv
interface b64w_in_if;
	logic                          valid;
	logic                          ready;
	logic [b64w_pkg::CharW-1:0]    char_code;
	logic                          end_of_string;

	modport source (output valid, char_code, end_of_string, input ready);
	modport sink (input valid, char_code, end_of_string, output ready);
endinterface

interface b64w_out_if;
	logic                          valid;
	logic                          ready;
	logic [b64w_pkg::WordW-1:0]    word_bits;
	logic [b64w_pkg::IndexW-1:0]   word_index;
	logic                          is_status;
	logic                          short_input;
	logic                          stopped_early;
	logic                          last_of_run;

	modport source (output valid, word_bits, word_index, is_status, short_input,
		stopped_early, last_of_run, input ready);
	modport sink (input valid, word_bits, word_index, is_status, short_input,
		stopped_early, last_of_run, output ready);
endinterface

### src/base64_to_word_decoder.sv
// Base64 character stream to 32-bit word decoder.
// chars: one ASCII character per transaction, end_of_string on the last one.
// words: decoded words (first byte in bits 7:0) with their index, and after
//   the last character one status transaction (short_input, stopped_early).
// cfg_we/cfg_wdata: float_count, the number of words expected; write only
//   while no transaction is in flight.
// Throughput: one character per cycle while the word channel keeps up; a
//   character that ends the string yields up to two transactions, and the
//   word channel moves one per cycle, so that sets the long-run rate.
// Path: a character is taken into the input register, and its results are
//   then written into the four-entry result queue that drives words.
// Reset: stream state clears and float_count returns to 128.
// Stall: the queue absorbs up to four results; chars.ready drops once the
//   queue cannot take two more, so nothing is lost or repeated.
`include "assert_macros.svh"

module base64_to_word_decoder #(
	parameter int unsigned MAX_WORDS = 65536
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [b64w_pkg::FcountW-1:0]   cfg_wdata,
	b64w_in_if.sink                        chars,
	b64w_out_if.source                     words
);

	localparam int unsigned CountW = $clog2(MAX_WORDS * 4 + 1);
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = 2;

	logic [b64w_pkg::FcountW-1:0]  fc_q;
	logic                          valid_s1;
	logic [b64w_pkg::CharW-1:0]    ch_s1;
	logic                          eos_s1;

	logic [1:0]                    qpos_q;
	logic [17:0]                   sextets_q;
	logic [5:0]                    classes_q;
	logic                          halted_q;
	logic [23:0]                   pw_q;
	logic [CountW-1:0]             bc_q;

	b64w_pkg::result_t             queue_q [QDepth];
	logic [QPtrW-1:0]              wr_q, rd_q;
	logic [QPtrW:0]                cnt_q;

	logic                          advance;
	logic                          pop;
	b64w_pkg::symbol_t             sym;
	logic [CountW-1:0]             limit;
	logic [CountW-1:0]             room;
	logic [1:0]                    n_en, n_keep;
	logic [7:0]                    bytes [3];
	logic [1:0]                    qpos_d;
	logic [17:0]                   sextets_d;
	logic [5:0]                    classes_d;
	logic                          halted_d;
	logic [23:0]                   pw_d;
	logic [CountW-1:0]             bc_d;
	logic                          have_word;
	logic [b64w_pkg::WordW-1:0]    word;
	logic [b64w_pkg::IndexW-1:0]   widx;
	b64w_pkg::result_t             word_res, stat_res, e0, e1;
	logic [1:0]                    n_push;

	assign advance     = valid_s1 && (cnt_q <= (QPtrW+1)'(QDepth - 2));
	assign chars.ready = !valid_s1 || advance;
	assign pop         = words.valid && words.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= b64w_pkg::FcountReset;
		end else if (cfg_we) begin
			fc_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1  <= chars.char_code;
			eos_s1 <= chars.end_of_string;
		end
	end

	always_comb begin
		logic [2:0]              lane;
		logic [CountW-1:0]       pos;
		logic [1:0]              s_lane;
		logic [5:0]              s0, s1, s2;
		logic [1:0]              c0, c1, c2;
		sym       = b64w_pkg::classify(ch_s1);
		limit     = (fc_q > b64w_pkg::FcountW'(MAX_WORDS)) ? CountW'(MAX_WORDS * 4)
			: CountW'({fc_q, 2'b00});
		room      = (bc_q >= limit) ? '0 : limit - bc_q;
		qpos_d    = qpos_q;
		sextets_d = sextets_q;
		classes_d = classes_q;
		halted_d  = halted_q;
		pw_d      = pw_q;
		bc_d      = bc_q;
		have_word = 1'b0;
		word      = '0;
		widx      = '0;
		n_en      = '0;
		n_keep    = '0;
		s0 = sextets_q[17:12];
		s1 = sextets_q[11:6];
		s2 = sextets_q[5:0];
		c0 = classes_q[5:4];
		c1 = classes_q[3:2];
		c2 = classes_q[1:0];
		bytes[0] = {s0, s1[5:4]};
		bytes[1] = {s1[3:0], s2[5:2]};
		bytes[2] = {s2[1:0], sym.val};
		lane = '0;
		pos  = bc_q;
		if (!halted_q) begin
			if (qpos_q != 2'd3) begin
				sextets_d = {sextets_q[11:0], sym.val};
				classes_d = {classes_q[3:0], sym.cls};
				qpos_d    = qpos_q + 2'd1;
			end else begin
				if (c0 != b64w_pkg::CLS_OK || c1 != b64w_pkg::CLS_OK) begin
					halted_d = 1'b1;
				end else if (c2 != b64w_pkg::CLS_OK) begin
					n_en = 2'd1;
				end else if (sym.cls != b64w_pkg::CLS_OK) begin
					n_en = 2'd2;
				end else begin
					n_en = 2'd3;
				end
				n_keep = (room < CountW'(n_en)) ? room[1:0] : n_en;
				for (int k = 0; k < 3; k++) begin
					if (k < n_keep) begin
						s_lane = pos[1:0];
						case (s_lane)
							2'd0: pw_d[7:0]   = bytes[k];
							2'd1: pw_d[15:8]  = bytes[k];
							2'd2: pw_d[23:16] = bytes[k];
							default: begin
								word      = {bytes[k], pw_d};
								widx      = b64w_pkg::IndexW'(pos >> 2);
								have_word = 1'b1;
								pw_d      = '0;
							end
						endcase
						pos  = pos + CountW'(1);
						lane = lane + 3'd1;
					end
				end
				bc_d      = pos;
				qpos_d    = '0;
				sextets_d = '0;
				classes_d = '0;
			end
		end
		word_res.word_bits     = word;
		word_res.word_index    = widx;
		word_res.is_status     = 1'b0;
		word_res.short_input   = 1'b0;
		word_res.stopped_early = 1'b0;
		word_res.last_of_run   = !eos_s1;
		stat_res.word_bits     = '0;
		stat_res.word_index    = '0;
		stat_res.is_status     = 1'b1;
		stat_res.short_input   = (bc_d < limit);
		stat_res.stopped_early = halted_d;
		stat_res.last_of_run   = 1'b1;
		e0     = have_word ? word_res : stat_res;
		e1     = stat_res;
		n_push = 2'(have_word) + 2'(eos_s1);
		if (lane > 3'd3) begin
			n_push = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qpos_q    <= '0;
			sextets_q <= '0;
			classes_q <= '0;
			halted_q  <= 1'b0;
			pw_q      <= '0;
			bc_q      <= '0;
		end else if (advance) begin
			if (eos_s1) begin
				qpos_q    <= '0;
				sextets_q <= '0;
				classes_q <= '0;
				halted_q  <= 1'b0;
				pw_q      <= '0;
				bc_q      <= '0;
			end else begin
				qpos_q    <= qpos_d;
				sextets_q <= sextets_d;
				classes_q <= classes_d;
				halted_q  <= halted_d;
				pw_q      <= pw_d;
				bc_q      <= bc_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && n_push != 2'd0) begin
			queue_q[wr_q] <= e0;
		end
		if (advance && n_push == 2'd2) begin
			queue_q[wr_q + QPtrW'(1)] <= e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (advance) begin
				wr_q <= wr_q + QPtrW'(n_push);
			end
			if (pop) begin
				rd_q <= rd_q + QPtrW'(1);
			end
			cnt_q <= cnt_q + (advance ? (QPtrW+1)'(n_push) : '0)
				- (QPtrW+1)'(pop);
		end
	end

	assign words.valid         = (cnt_q != '0);
	assign words.word_bits     = queue_q[rd_q].word_bits;
	assign words.word_index    = queue_q[rd_q].word_index;
	assign words.is_status     = queue_q[rd_q].is_status;
	assign words.short_input   = queue_q[rd_q].short_input;
	assign words.stopped_early = queue_q[rd_q].stopped_early;
	assign words.last_of_run   = queue_q[rd_q].last_of_run;

	`ASSERT_ALWAYS(a_queue_bound, cnt_q <= (QPtrW+1)'(QDepth), "result queue overflow")
	`ASSERT_IMPLIES(a_status_last, words.valid && words.is_status,
		words.last_of_run && words.word_bits == '0, "malformed status transaction")
	`ASSERT_IMPLIES(a_word_flags, words.valid && !words.is_status,
		!words.short_input && !words.stopped_early, "status flags on a word")
	`ASSERT_IMPLIES(a_input_stall, valid_s1 && !advance, !chars.ready,
		"character taken while the input stage is held")

endmodule
